// ===== hdl/entab_pkg.sv =====
// Shared types and constants for the blank-to-tab compression block.
package entab_pkg;

  // Character codes the block treats specially.
  localparam logic [7:0] CharBlank   = 8'h20;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharNewline = 8'h0A;

  // Fixed field widths.
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned CountWidth = 6;
  localparam int unsigned ColWidth   = 8;
  localparam int unsigned StopWidth  = 64;
  localparam int unsigned MapWidth   = 2 * StopWidth;
  localparam int unsigned MapIdxWidth = $clog2(MapWidth);

  // Register indexes of the configuration port.
  localparam logic CfgStopsLow  = 1'b0;
  localparam logic CfgStopsHigh = 1'b1;

  // Reset value of both stop registers: a stop every eight columns.
  localparam logic [StopWidth-1:0] StopReset = 64'h8080_8080_8080_8080;

  // One command from the front to the back: a run to emit and the closing byte.
  typedef struct packed {
    logic [CountWidth-1:0] tabs;
    logic [CountWidth-1:0] blanks;
    logic [CharWidth-1:0]  ch;
  } cmd_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage

// ===== hdl/entab_front.sv =====
// Front part: accepts bytes, tracks column and pending run, issues commands.
module entab_front #(
  parameter int unsigned TABLE_COLUMNS = 128,
  parameter int unsigned MAX_PENDING   = 63
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [entab_pkg::CharWidth-1:0]      in_char_i,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_index_i,
  input  logic [entab_pkg::StopWidth-1:0]      cfg_data_i,
  input  entab_pkg::queue_status_t             q_status_i,
  output logic                                 push_o,
  output entab_pkg::cmd_t                      push_cmd_o
);

  localparam logic [entab_pkg::ColWidth-1:0] ColLimit =
    entab_pkg::ColWidth'(TABLE_COLUMNS + 1);
  localparam logic [entab_pkg::ColWidth-1:0] ColLast =
    entab_pkg::ColWidth'(TABLE_COLUMNS);
  localparam logic [entab_pkg::CountWidth:0] PendLimit =
    (entab_pkg::CountWidth + 1)'(MAX_PENDING);

  // Front states.
  localparam logic StIdle = 1'b0;
  localparam logic StSeek = 1'b1;

  logic                                  state_q, state_d;
  logic [entab_pkg::ColWidth-1:0]        col_q, col_d;
  logic [entab_pkg::CountWidth-1:0]      ptabs_q, ptabs_d;
  logic [entab_pkg::CountWidth-1:0]      pblanks_q, pblanks_d;
  logic [entab_pkg::StopWidth-1:0]       stops_lo_q, stops_hi_q;
  logic [entab_pkg::MapWidth-1:0]        stop_map;
  logic [entab_pkg::ColWidth-1:0]        col_m1;
  logic                                  at_stop;
  logic [entab_pkg::ColWidth-1:0]        col_next;
  logic                                  accept;
  logic [entab_pkg::CountWidth:0]        nt, nb;
  logic [entab_pkg::CountWidth:0]        nsum;

  // Stop lookup for the current column; columns past the table are stops.
  assign stop_map = {stops_hi_q, stops_lo_q};
  assign col_m1   = col_q - 1'b1;
  assign at_stop  = (col_q == '0) || (col_q > ColLast) ||
                    stop_map[col_m1[entab_pkg::MapIdxWidth-1:0]];
  assign col_next = (col_q >= ColLimit) ? ColLimit : col_q + 1'b1;

  assign in_stall_o = (state_q == StSeek) || q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // Pending run update for a blank.
  always_comb begin
    if (at_stop) begin
      nt = {1'b0, ptabs_q} + 1'b1;
      nb = '0;
    end else begin
      nt = {1'b0, ptabs_q};
      nb = {1'b0, pblanks_q} + 1'b1;
    end
    nsum = nt + nb;
  end

  // A non-blank byte closes the run and goes to the back as one command.
  assign push_o            = accept && (in_char_i != entab_pkg::CharBlank);
  assign push_cmd_o.tabs   = ptabs_q;
  assign push_cmd_o.blanks = (in_char_i == entab_pkg::CharTab) ? '0 : pblanks_q;
  assign push_cmd_o.ch     = in_char_i;

  // Column and pending-run control, with a stepwise search for the next stop.
  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    ptabs_d   = ptabs_q;
    pblanks_d = pblanks_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_char_i == entab_pkg::CharBlank) begin
            if (nsum <= PendLimit) begin
              ptabs_d   = nt[entab_pkg::CountWidth-1:0];
              pblanks_d = nb[entab_pkg::CountWidth-1:0];
            end
            col_d = col_next;
          end else begin
            ptabs_d   = '0;
            pblanks_d = '0;
            if (in_char_i == entab_pkg::CharNewline) begin
              col_d = entab_pkg::ColWidth'(1);
            end else if (in_char_i == entab_pkg::CharTab) begin
              state_d = StSeek;
            end else begin
              col_d = col_next;
            end
          end
        end
      end
      StSeek: begin
        col_d = col_next;
        if (at_stop) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      col_q     <= entab_pkg::ColWidth'(1);
      ptabs_q   <= '0;
      pblanks_q <= '0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      ptabs_q   <= ptabs_d;
      pblanks_q <= pblanks_d;
    end
  end

  // Tab-stop registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stops_lo_q <= entab_pkg::StopReset;
      stops_hi_q <= entab_pkg::StopReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        entab_pkg::CfgStopsLow:  stops_lo_q <= cfg_data_i;
        entab_pkg::CfgStopsHigh: stops_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/entab_queue.sv =====
// Two-entry command queue between the front and the back.
module entab_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  entab_pkg::cmd_t           push_cmd_i,
  input  logic                      pop_i,
  output entab_pkg::cmd_t           head_o,
  output entab_pkg::queue_status_t  status_o
);

  entab_pkg::cmd_t slot_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;

  assign head_o             = slot_q[rd_ptr_q];
  assign status_o.full      = (count_q == 2'd2);
  assign status_o.not_empty = (count_q != 2'd0);

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/entab_back.sv =====
// Back part: expands each command into tabs, blanks and the closing byte.
module entab_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  entab_pkg::cmd_t                  head_i,
  input  entab_pkg::queue_status_t         q_status_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [entab_pkg::CharWidth-1:0]  out_char_o,
  output logic                             out_last_of_run_o
);

  logic                                 job_q;
  logic [entab_pkg::CountWidth-1:0]     tabs_q, tabs_d;
  logic [entab_pkg::CountWidth-1:0]     blanks_q, blanks_d;
  logic [entab_pkg::CharWidth-1:0]      ch_q, ch_d;
  logic                                 out_valid_q, out_valid_d;
  logic [entab_pkg::CharWidth-1:0]      out_char_q, out_char_d;
  logic                                 out_last_q, out_last_d;
  logic                                 advance, emit, job_done;

  assign advance  = !out_valid_q || !out_stall_i;
  assign emit     = advance && job_q;
  assign job_done = emit && (tabs_q == '0) && (blanks_q == '0);
  assign pop_o    = q_status_i.not_empty && (!job_q || job_done);

  // Next output byte and job countdown.
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    tabs_d      = tabs_q;
    blanks_d    = blanks_q;
    ch_d        = ch_q;
    if (emit) begin
      out_valid_d = 1'b1;
      priority if (tabs_q != '0) begin
        out_char_d = entab_pkg::CharTab;
        out_last_d = 1'b0;
        tabs_d     = tabs_q - 1'b1;
      end else if (blanks_q != '0) begin
        out_char_d = entab_pkg::CharBlank;
        out_last_d = 1'b0;
        blanks_d   = blanks_q - 1'b1;
      end else begin
        out_char_d = ch_q;
        out_last_d = 1'b1;
      end
    end else if (advance) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      tabs_d   = head_i.tabs;
      blanks_d = head_i.blanks;
      ch_d     = head_i.ch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        job_q <= 1'b1;
      end else if (job_done) begin
        job_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    tabs_q     <= tabs_d;
    blanks_q   <= blanks_d;
    ch_q       <= ch_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_char_o        = out_char_q;
  assign out_last_of_run_o = out_last_q;

endmodule

// ===== hdl/entab_with_tab_stop_table.sv =====
// Top level of the blank-to-tab compression block with a tab-stop table.
// Usage: bytes enter on the input channel (in_valid_i, in_stall_o, in_char_i)
// and leave on the output channel (out_valid_o, out_stall_i, out_char_o,
// out_last_of_run_o). A transaction moves one byte at an edge with valid high
// and stall low. A blank produces no output; any other byte produces the
// pending tabs, then the pending blanks (none for a tab byte), then the byte
// itself with out_last_of_run_o set.
// Throughput: while out_stall_i is low, the back emits one byte per cycle and
// fetches the next command in the cycle that emits the last byte of the
// current one. A steady stream of plain bytes therefore moves at one byte per
// cycle when the receiver does not stall. A tab byte holds the front, with
// in_stall_o high, while it steps column by column through the stop table.
// A two-entry command queue separates front and back, so input keeps flowing
// while the receiver stalls until the queue fills; output bytes hold steady
// while stalled. Reset sets column 1, clears the pending run and the queue,
// and loads a stop every eight columns into both stop registers.
module entab_with_tab_stop_table #(
  parameter int unsigned TABLE_COLUMNS = 128,
  parameter int unsigned MAX_PENDING   = 63
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [entab_pkg::CharWidth-1:0]  in_char_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [entab_pkg::CharWidth-1:0]  out_char_o,
  output logic                             out_last_of_run_o,
  input  logic                             cfg_we_i,
  input  logic                             cfg_index_i,
  input  logic [entab_pkg::StopWidth-1:0]  cfg_data_i
);

  logic                      push, pop;
  entab_pkg::cmd_t           push_cmd, head;
  entab_pkg::queue_status_t  q_status;

  entab_front #(
    .TABLE_COLUMNS (TABLE_COLUMNS),
    .MAX_PENDING   (MAX_PENDING)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_char_i   (in_char_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  entab_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  entab_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .q_status_i        (q_status),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_char_o        (out_char_o),
    .out_last_of_run_o (out_last_of_run_o)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the blank-to-tab compression block with a tab-stop table.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned TableColumns = 128;
  localparam int unsigned MaxPending   = 63;
  localparam int unsigned ColLimit     = TableColumns + 1;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainCycles  = 16;

  // How a row of the opening table is checked.
  typedef enum logic [1:0] {
    ROW_ECHO,   // only the byte itself comes out, marked last
    ROW_QUIET,  // nothing comes out
    ROW_CALC    // the predictor works out the output
  } row_kind_e;

  typedef struct packed {
    logic [entab_pkg::CharWidth-1:0] ch;
    row_kind_e                       kind;
  } text_row_t;

  typedef struct packed {
    logic [entab_pkg::CharWidth-1:0] ch;
    logic                            last;
  } out_byte_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [entab_pkg::CharWidth-1:0] in_char_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [entab_pkg::CharWidth-1:0] out_char_o;
  logic                            out_last_of_run_o;
  logic                            cfg_we_i;
  logic                            cfg_index_i;
  logic [entab_pkg::StopWidth-1:0] cfg_data_i;

  // Predictor state: its own copy of the stop table, column and pending run.
  logic [entab_pkg::StopWidth-1:0] stops_lo;
  logic [entab_pkg::StopWidth-1:0] stops_hi;
  int unsigned                     col_now;
  int unsigned                     tabs_owed;
  int unsigned                     blanks_owed;

  // Output bytes still owed by the block, oldest first.
  out_byte_t            predicted_out[$];
  out_byte_t            got;
  out_byte_t            want;

  bit                   steady;
  int unsigned          cycles;
  int unsigned          errors;
  int unsigned          sent;
  int unsigned          checked;
  int unsigned          run_drops;
  int unsigned          settings;
  int unsigned          run_len;
  int unsigned          longest_run;

  // Opening sequence under the reset stop table (a stop every eight columns).
  text_row_t opening_rows [24] = '{
    '{8'h41, ROW_ECHO},                   // plain letter in column 1
    '{8'h00, ROW_ECHO},                   // lowest byte
    '{8'hFF, ROW_ECHO},                   // highest byte
    '{entab_pkg::CharNewline, ROW_ECHO},  // back to column 1
    '{entab_pkg::CharBlank, ROW_QUIET},
    '{entab_pkg::CharBlank, ROW_QUIET},
    '{8'h62, ROW_CALC},                   // two blanks flushed before the letter
    '{entab_pkg::CharTab, ROW_ECHO},      // tab with nothing pending, column 4 to 9
    '{entab_pkg::CharBlank, ROW_QUIET},
    '{entab_pkg::CharBlank, ROW_QUIET},
    '{entab_pkg::CharTab, ROW_CALC},      // pending blanks dropped by a tab byte
    '{entab_pkg::CharBlank, ROW_QUIET},   // columns 17 to 24: the eighth blank hits a stop
    '{entab_pkg::CharBlank, ROW_QUIET},
    '{entab_pkg::CharBlank, ROW_QUIET},
    '{entab_pkg::CharBlank, ROW_QUIET},
    '{entab_pkg::CharBlank, ROW_QUIET},
    '{entab_pkg::CharBlank, ROW_QUIET},
    '{entab_pkg::CharBlank, ROW_QUIET},
    '{entab_pkg::CharBlank, ROW_QUIET},
    '{entab_pkg::CharBlank, ROW_QUIET},   // one blank after the stop
    '{8'h7A, ROW_CALC},                   // tab, blank, then the letter
    '{entab_pkg::CharNewline, ROW_ECHO},
    '{entab_pkg::CharTab, ROW_ECHO},      // tab from column 1
    '{8'h7F, ROW_ECHO}
  };

  entab_with_tab_stop_table #(
    .TABLE_COLUMNS(TableColumns),
    .MAX_PENDING  (MaxPending)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_char_i        (in_char_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_char_o       (out_char_o),
    .out_last_of_run_o(out_last_of_run_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Columns past the table, and the impossible column 0, are always stops.
  function automatic bit is_tab_stop(input int unsigned col);
    if (col > TableColumns || col == 0) return 1'b1;
    if (col <= entab_pkg::StopWidth) return stops_lo[col-1];
    return stops_hi[col-1-entab_pkg::StopWidth];
  endfunction

  function automatic int unsigned step_col(input int unsigned col);
    return (col >= ColLimit) ? ColLimit : col + 1;
  endfunction

  // Advance the predicted state by one byte and queue the bytes it releases.
  task automatic entab_predict(input logic [entab_pkg::CharWidth-1:0] ch, input bit keep);
    int unsigned nt;
    int unsigned nb;
    if (ch == entab_pkg::CharBlank) begin
      nt = tabs_owed;
      nb = blanks_owed;
      if (is_tab_stop(col_now)) begin
        nb = 0;
        nt = nt + 1;
      end else begin
        nb = nb + 1;
      end
      if (nt + nb <= MaxPending) begin
        tabs_owed   = nt;
        blanks_owed = nb;
      end else begin
        run_drops++;
      end
      col_now = step_col(col_now);
    end else begin
      if (keep) begin
        repeat (tabs_owed) begin
          predicted_out.push_back(out_byte_t'{ch: entab_pkg::CharTab, last: 1'b0});
        end
        if (ch != entab_pkg::CharTab) begin
          repeat (blanks_owed) begin
            predicted_out.push_back(out_byte_t'{ch: entab_pkg::CharBlank, last: 1'b0});
          end
        end
        predicted_out.push_back(out_byte_t'{ch: ch, last: 1'b1});
      end
      tabs_owed   = 0;
      blanks_owed = 0;
      if (ch == entab_pkg::CharNewline) begin
        col_now = 1;
      end else begin
        if (ch == entab_pkg::CharTab) begin
          while (!is_tab_stop(col_now)) col_now = step_col(col_now);
        end
        col_now = step_col(col_now);
      end
    end
  endtask

  task automatic report_error(input string msg);
    $display("ERROR cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // Offer one byte, with an occasional gap first, and wait for the transaction.
  task automatic send_byte(input logic [entab_pkg::CharWidth-1:0] ch,
                           input row_kind_e kind);
    if (!steady && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_char_i  <= ch;
    entab_predict(ch, kind == ROW_CALC);
    if (kind == ROW_ECHO) predicted_out.push_back(out_byte_t'{ch: ch, last: 1'b1});
    sent++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic cfg_write(input logic idx, input logic [entab_pkg::StopWidth-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx == entab_pkg::CfgStopsLow) stops_lo = data;
    else stops_hi = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Let every owed byte come out, any tab search finish, and the block fall quiet.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (predicted_out.size() != 0 || in_stall_o) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Random text: words, blank runs (some long enough to fill the run), tabs,
  // newlines and arbitrary bytes.
  task automatic run_text(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    start = sent;
    while (sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(126, 33)), ROW_CALC);
      end else if (pick < 73) begin
        repeat ($urandom_range(12, 1)) send_byte(entab_pkg::CharBlank, ROW_CALC);
      end else if (pick < 78) begin
        repeat ($urandom_range(75, 60)) send_byte(entab_pkg::CharBlank, ROW_CALC);
      end else if (pick < 87) begin
        send_byte(entab_pkg::CharTab, ROW_CALC);
      end else if (pick < 93) begin
        send_byte(entab_pkg::CharNewline, ROW_CALC);
      end else begin
        send_byte(8'($urandom_range(255, 0)), ROW_CALC);
      end
    end
  endtask

  // Check each output transaction and pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = out_byte_t'{ch: out_char_o, last: out_last_of_run_o};
      if (predicted_out.size() == 0) begin
        report_error($sformatf("unexpected output byte %02h", got.ch));
      end else begin
        want = predicted_out.pop_front();
        if (got.ch !== want.ch) begin
          report_error($sformatf("out_char %02h, predicted %02h", got.ch, want.ch));
        end
        if (got.last !== want.last) begin
          report_error($sformatf("last_of_run %b, predicted %b", got.last, want.last));
        end
        checked++;
      end
      run_len++;
      if (run_len > longest_run) longest_run = run_len;
      if (got.last) run_len = 0;
    end
    out_stall_i <= !steady && ($urandom_range(99) < 30);
  end

  // Cycle count and run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Run limit of %0d cycles reached with %0d bytes owed.", CycleLimit,
               predicted_out.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_char_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = entab_pkg::CfgStopsLow;
    cfg_data_i  = '0;
    steady      = 1'b0;
    cycles      = 0;
    errors      = 0;
    sent        = 0;
    checked     = 0;
    run_drops   = 0;
    run_len     = 0;
    longest_run = 0;
    stops_lo    = entab_pkg::StopReset;
    stops_hi    = entab_pkg::StopReset;
    col_now     = 1;
    tabs_owed   = 0;
    blanks_owed = 0;
    settings    = 1;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening under the reset stop table.
    for (k = 0; k < 24; k++) send_byte(opening_rows[k].ch, opening_rows[k].kind);
    settle_idle();

    // No stops in the table: runs fill up and tabs search to the end.
    cfg_write(entab_pkg::CfgStopsLow, '0);
    cfg_write(entab_pkg::CfgStopsHigh, '0);
    settings++;
    run_text(50);
    settle_idle();

    // Every column a stop.
    cfg_write(entab_pkg::CfgStopsLow, '1);
    cfg_write(entab_pkg::CfgStopsHigh, '1);
    settings++;
    run_text(50);
    settle_idle();

    cfg_write(entab_pkg::CfgStopsLow, {$urandom, $urandom});
    cfg_write(entab_pkg::CfgStopsHigh, {$urandom, $urandom});
    settings++;
    run_text(50);
    settle_idle();

    // Only the low half changes.
    cfg_write(entab_pkg::CfgStopsLow, {$urandom, $urandom});
    settings++;
    run_text(50);
    settle_idle();

    // Back to the reset table with both sides running flat out.
    cfg_write(entab_pkg::CfgStopsLow, entab_pkg::StopReset);
    cfg_write(entab_pkg::CfgStopsHigh, entab_pkg::StopReset);
    settings++;
    steady = 1'b1;
    run_text(50);
    settle_idle();
    steady = 1'b0;

    // Sparse random stops.
    cfg_write(entab_pkg::CfgStopsLow, {$urandom, $urandom} & {$urandom, $urandom});
    cfg_write(entab_pkg::CfgStopsHigh, {$urandom, $urandom} & {$urandom, $urandom});
    settings++;
    run_text(50);

    // Trailing blanks stay pending and never come out.
    send_byte(entab_pkg::CharBlank, ROW_QUIET);
    send_byte(entab_pkg::CharBlank, ROW_QUIET);
    settle_idle();

    $display("Sent %0d bytes under %0d stop tables; %0d blanks dropped on a full run.",
             sent, settings, run_drops);
    $display("Checked %0d output bytes; longest output run from one byte was %0d.",
             checked, longest_run);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/entab_pkg.sv
hdl/entab_front.sv
hdl/entab_queue.sv
hdl/entab_back.sv
hdl/entab_with_tab_stop_table.sv
verif/testbench.sv
